### src/ppbr_pkg.sv
package ppbr_pkg;

	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_POP     = 3'd1;
	localparam logic [2:0] OP_DROP    = 3'd2;
	localparam logic [2:0] OP_SWAP    = 3'd3;
	localparam logic [2:0] OP_RESTART = 3'd4;

	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_A2B  = 2'd1;
	localparam logic [1:0] MODE_B2A  = 2'd2;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       drop;
		logic       clr;
		logic [7:0] data;
		logic [7:0] n;
	} ring_cmd_t;

endpackage

### src/ping_pong_byte_ring_buffer_unit.sv
// Ping-pong pair of byte rings A and B with a three-way mode.
// Input channel (in_valid/in_ready): one word carries opcode, push_byte and
// drop_count. Opcodes: push, pop, drop newest, swap mode, restart ring A.
// Output channel (out_valid/out_ready): one word per input word with the
// popped byte, the empty flag, the mode and both fill levels after the op.
// The word is registered at input acceptance, then applied to the ring
// pointers and memories as it moves into the result register; the popped
// byte comes from the registered read port of the ring memory.
// Throughput: one word per cycle while the receiver does not stall, set by
// the pointer update and the one write plus one read port of each ring memory.
// When the receiver stalls, the result holds and one more word is taken
// into the input register; in_ready then drops until the result leaves.
// Reset empties both rings and selects pass-through mode; memory contents
// are not cleared, since a pop only reaches bytes that a push wrote.
module ping_pong_byte_ring_buffer_unit #(
	parameter int DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] opcode,
	input  logic [7:0] push_byte,
	input  logic [7:0] drop_count,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_byte,
	output logic       read_was_empty,
	output logic [1:0] mode_now,
	output logic [8:0] fill_a,
	output logic [8:0] fill_b
);
	import ppbr_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          v_s1, v_s2;
	logic [2:0]    op_s1;
	logic [7:0]    byte_s1, n_s1;
	logic          got_s2, empty_s2, selb_s2;
	logic [1:0]    mode_q, mode_nx;
	logic          adv, got, empty, sel_b;
	ring_cmd_t     cmd_a, cmd_b;
	logic [CW-1:0] count_a, count_b;
	logic [7:0]    rd_a, rd_b;

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			mode_q <= MODE_PASS;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv) begin
				v_s2   <= 1'b1;
				mode_q <= mode_nx;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= opcode;
			byte_s1 <= push_byte;
			n_s1    <= drop_count;
		end
		if (adv) begin
			got_s2   <= got;
			empty_s2 <= empty;
			selb_s2  <= sel_b;
		end
	end

	ppbr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.op      (op_s1),
		.data    (byte_s1),
		.n       (n_s1),
		.mode    (mode_q),
		.count_a (count_a),
		.count_b (count_b),
		.cmd_a   (cmd_a),
		.cmd_b   (cmd_b),
		.mode_nx (mode_nx),
		.got     (got),
		.empty   (empty),
		.sel_b   (sel_b)
	);

	ppbr_ring #(.DEPTH(DEPTH)) u_ring_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.cmd     (cmd_a),
		.count   (count_a),
		.rd_data (rd_a)
	);

	ppbr_ring #(.DEPTH(DEPTH)) u_ring_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.cmd     (cmd_b),
		.count   (count_b),
		.rd_data (rd_b)
	);

	assign out_valid      = v_s2;
	assign read_byte      = got_s2 ? (selb_s2 ? rd_b : rd_a) : 8'h00;
	assign read_was_empty = empty_s2;
	assign mode_now       = mode_q;
	assign fill_a         = 9'(count_a);
	assign fill_b         = 9'(count_b);

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> $stable(mode_q) && $stable(count_a) && $stable(count_b))
		else $error("state moved while result stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(got_s2 && empty_s2))
		else $error("pop both delivered and empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && !out_ready)
		else $error("input stalled without a full pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_a.pop |-> count_a != '0)
		else $error("pop issued to empty ring A");

endmodule

### src/ppbr_ring.sv
module ppbr_ring #(
	parameter int DEPTH = 256,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ppbr_pkg::ring_cmd_t cmd,
	output logic [CW-1:0]      count,
	output logic [7:0]         rd_data
);
	import ppbr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int DW = ((CW > 8) ? CW : 8) + 1;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] head_nx, tail_nx;
	logic [DW-1:0] back, back_w;
	logic          full, too_many;

	assign full     = (count_q >= CW'(DEPTH));
	assign head_nx  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
	assign tail_nx  = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
	assign too_many = (DW'(cmd.n) > DW'(count_q)) || (cmd.n == 8'd0);
	assign back     = DW'(tail_q) - DW'(cmd.n);
	assign back_w   = back[DW-1] ? back + DW'(DEPTH) : back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (en) begin
			if (cmd.clr || (cmd.drop && too_many)) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.drop) begin
				tail_q  <= back_w[PW-1:0];
				count_q <= count_q - CW'(cmd.n);
			end else if (cmd.push) begin
				tail_q <= tail_nx;
				if (full) begin
					head_q <= head_nx;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (cmd.pop) begin
				head_q  <= head_nx;
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && cmd.push) begin
			mem[tail_q] <= cmd.data;
		end
		if (en) begin
			rd_q <= mem[head_q];
		end
	end

	assign count   = count_q;
	assign rd_data = rd_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("ring fill above depth");

endmodule

### src/ppbr_ctrl.sv
module ppbr_ctrl #(
	parameter int DEPTH = 256,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic [2:0]          op,
	input  logic [7:0]          data,
	input  logic [7:0]          n,
	input  logic [1:0]          mode,
	input  logic [CW-1:0]       count_a,
	input  logic [CW-1:0]       count_b,
	output ppbr_pkg::ring_cmd_t cmd_a,
	output ppbr_pkg::ring_cmd_t cmd_b,
	output logic [1:0]          mode_nx,
	output logic                got,
	output logic                empty,
	output logic                sel_b
);
	import ppbr_pkg::*;

	logic wr_b;

	assign wr_b  = (mode == MODE_A2B);
	assign sel_b = (mode == MODE_B2A);

	always_comb begin
		cmd_a      = '0;
		cmd_b      = '0;
		cmd_a.data = data;
		cmd_b.data = data;
		cmd_a.n    = n;
		cmd_b.n    = n;
		mode_nx    = mode;
		got        = 1'b0;
		empty      = 1'b0;
		case (op)
			OP_PUSH: begin
				if (wr_b) cmd_b.push = 1'b1;
				else cmd_a.push = 1'b1;
			end
			OP_POP: begin
				if ((sel_b ? count_b : count_a) == '0) begin
					empty = 1'b1;
				end else begin
					got = 1'b1;
					if (sel_b) cmd_b.pop = 1'b1;
					else cmd_a.pop = 1'b1;
				end
			end
			OP_DROP: begin
				if (wr_b) cmd_b.drop = 1'b1;
				else cmd_a.drop = 1'b1;
			end
			OP_SWAP: begin
				if (mode == MODE_PASS) begin
					mode_nx = MODE_A2B;
				end else if (mode == MODE_A2B) begin
					if (count_a == '0) mode_nx = MODE_B2A;
					else cmd_b.clr = 1'b1;
				end else begin
					if (count_b == '0) mode_nx = MODE_A2B;
					else cmd_a.clr = 1'b1;
				end
			end
			OP_RESTART: begin
				cmd_a.clr = 1'b1;
				mode_nx   = MODE_PASS;
			end
			default: begin
			end
		endcase
	end

endmodule

### tb/ping_pong_byte_ring_buffer_unit_test.sv
module ping_pong_byte_ring_buffer_unit_test;
	import ppbr_pkg::*;

	localparam int RING_A = 0;
	localparam int RING_B = 1;
	localparam int RING_DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		logic [7:0] read_byte;
		logic       read_was_empty;
		logic [1:0] mode_now;
		logic [8:0] fill_a;
		logic [8:0] fill_b;
	} ring_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] opcode;
	logic [7:0] push_byte;
	logic [7:0] drop_count;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_byte;
	logic       read_was_empty;
	logic [1:0] mode_now;
	logic [8:0] fill_a;
	logic [8:0] fill_b;

	logic [7:0] ring_mem [2][RING_DEPTH];
	logic [7:0] ring_head [2];
	logic [7:0] ring_tail [2];
	logic [8:0] ring_fill [2];
	logic [1:0] ring_mode;

	ring_result_t pending_results[$];
	int mismatch_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_left = 0;
	int quiet_cycles = 0;

	ping_pong_byte_ring_buffer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.push_byte     (push_byte),
		.drop_count    (drop_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_byte     (read_byte),
		.read_was_empty(read_was_empty),
		.mode_now      (mode_now),
		.fill_a        (fill_a),
		.fill_b        (fill_b)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_ring(input int idx);
		ring_head[idx] = 8'd0;
		ring_tail[idx] = 8'd0;
		ring_fill[idx] = 9'd0;
	endfunction

	function automatic int write_ring();
		return (ring_mode == MODE_A2B) ? RING_B : RING_A;
	endfunction

	function automatic void predict_word(input logic [2:0] op, input logic [7:0] data,
			input logic [7:0] cnt);
		ring_result_t r;
		int wr;
		int rd;
		wr = write_ring();
		rd = (ring_mode == MODE_B2A) ? RING_B : RING_A;
		r.read_byte = 8'd0;
		r.read_was_empty = 1'b0;
		case (op)
			OP_PUSH: begin
				ring_mem[wr][ring_tail[wr]] = data;
				ring_tail[wr] = ring_tail[wr] + 8'd1;
				if (ring_fill[wr] == RING_DEPTH)
					ring_head[wr] = ring_head[wr] + 8'd1;
				else
					ring_fill[wr] = ring_fill[wr] + 9'd1;
			end
			OP_POP: begin
				if (ring_fill[rd] == 0) begin
					r.read_was_empty = 1'b1;
				end else begin
					r.read_byte = ring_mem[rd][ring_head[rd]];
					ring_head[rd] = ring_head[rd] + 8'd1;
					ring_fill[rd] = ring_fill[rd] - 9'd1;
				end
			end
			OP_DROP: begin
				if (cnt == 8'd0 || 9'(cnt) > ring_fill[wr]) begin
					clear_ring(wr);
				end else begin
					ring_fill[wr] = ring_fill[wr] - 9'(cnt);
					ring_tail[wr] = ring_tail[wr] - cnt;
				end
			end
			OP_SWAP: begin
				if (ring_mode == MODE_PASS) begin
					ring_mode = MODE_A2B;
				end else if (ring_mode == MODE_A2B) begin
					if (ring_fill[RING_A] == 0)
						ring_mode = MODE_B2A;
					else
						clear_ring(RING_B);
				end else begin
					if (ring_fill[RING_B] == 0)
						ring_mode = MODE_A2B;
					else
						clear_ring(RING_A);
				end
			end
			OP_RESTART: begin
				clear_ring(RING_A);
				ring_mode = MODE_PASS;
			end
			default: begin
			end
		endcase
		r.mode_now = ring_mode;
		r.fill_a = ring_fill[RING_A];
		r.fill_b = ring_fill[RING_B];
		pending_results.push_back(r);
	endfunction

	task automatic send_word(input logic [2:0] op, input logic [7:0] data,
			input logic [7:0] cnt);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		push_byte <= data;
		drop_count <= cnt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_word(op, data, cnt);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_word();
		int pick;
		int wr_fill;
		logic [2:0] op;
		logic [7:0] n;
		pick = $urandom_range(99);
		if (pick < 40)
			op = OP_PUSH;
		else if (pick < 70)
			op = OP_POP;
		else if (pick < 78)
			op = OP_DROP;
		else if (pick < 88)
			op = OP_SWAP;
		else if (pick < 93)
			op = OP_RESTART;
		else
			op = 3'($urandom_range(7, 5));
		n = 8'($urandom_range(255));
		wr_fill = ring_fill[write_ring()];
		if (op == OP_DROP) begin
			case ($urandom_range(3))
				0: n = 8'd0;
				1: if (wr_fill > 0)
					n = 8'($urandom_range((wr_fill > 255) ? 255 : wr_fill, 1));
				2: if (wr_fill < 255)
					n = 8'($urandom_range(255, wr_fill + 1));
				default: begin
				end
			endcase
		end
		send_word(op, 8'($urandom_range(255)), n);
	endtask

	function automatic void check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			mismatch_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
				act_val);
		end
	endfunction

	task automatic check_result();
		ring_result_t exp_r;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected word: expected none, actual read_byte %0d mode %0d",
				$time, read_byte, mode_now);
		end else begin
			exp_r = pending_results.pop_front();
			check_field("read_byte", exp_r.read_byte, read_byte);
			check_field("read_was_empty", exp_r.read_was_empty, read_was_empty);
			check_field("mode_now", exp_r.mode_now, mode_now);
			check_field("fill_a", exp_r.fill_a, fill_a);
			check_field("fill_b", exp_r.fill_b, fill_b);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result();
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ping_pong_byte_ring_buffer_unit_test: FAIL");
		$finish;
	end

	task automatic test_directed_ops();
		send_word(OP_POP, 8'h00, 8'h00);
		send_word(OP_PUSH, 8'h00, 8'h00);
		send_word(OP_PUSH, 8'hFF, 8'hFF);
		send_word(OP_POP, 8'hFF, 8'h00);
		send_word(OP_POP, 8'h00, 8'hFF);
		send_word(OP_PUSH, 8'h5A, 8'h00);
		send_word(OP_DROP, 8'h00, 8'd0);
		send_word(OP_PUSH, 8'hA5, 8'h00);
		send_word(OP_PUSH, 8'h3C, 8'h00);
		send_word(OP_PUSH, 8'hC3, 8'h00);
		send_word(OP_DROP, 8'h00, 8'd1);
		send_word(OP_DROP, 8'hFF, 8'd255);
		send_word(OP_PUSH, 8'h11, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		send_word(OP_PUSH, 8'h22, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		send_word(OP_PUSH, 8'h33, 8'h00);
		send_word(OP_POP, 8'h00, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		send_word(OP_PUSH, 8'h44, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		send_word(OP_POP, 8'h00, 8'h00);
		send_word(OP_POP, 8'h00, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		send_word(OP_RESTART, 8'hFF, 8'hFF);
		send_word(3'd5, 8'hFF, 8'h00);
		send_word(3'd6, 8'h00, 8'hFF);
		send_word(3'd7, 8'hFF, 8'hFF);
		drain_results();
	endtask

	task automatic test_ring_overwrite();
		int i;
		for (i = 0; i < 270; i++)
			send_word(OP_PUSH, 8'($urandom_range(255)), 8'($urandom_range(255)));
		for (i = 0; i < 5; i++)
			send_word(OP_POP, 8'($urandom_range(255)), 8'($urandom_range(255)));
		send_word(OP_DROP, 8'h00, 8'd255);
		send_word(OP_POP, 8'h00, 8'h00);
		send_word(OP_RESTART, 8'h00, 8'h00);
		send_word(OP_SWAP, 8'h00, 8'h00);
		for (i = 0; i < 258; i++)
			send_word(OP_PUSH, 8'($urandom_range(255)), 8'($urandom_range(255)));
		send_word(OP_SWAP, 8'h00, 8'h00);
		for (i = 0; i < 5; i++)
			send_word(OP_POP, 8'($urandom_range(255)), 8'($urandom_range(255)));
		send_word(OP_RESTART, 8'h00, 8'h00);
		drain_results();
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
		int i;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++) begin
			send_random_word();
			if (i == count / 2)
				drain_results();
		end
		drain_results();
	endtask

	task automatic test_output_backpressure();
		int i;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = HOLD_OFF_CYCLES;
		for (i = 0; i < 40; i++)
			send_random_word();
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_PUSH;
		push_byte <= 8'd0;
		drop_count <= 8'd0;
		out_ready <= 1'b0;
		ring_mode = MODE_PASS;
		clear_ring(RING_A);
		clear_ring(RING_B);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 11;
		recv_stall_pct = 63;
		test_directed_ops();
		test_ring_overwrite();
		test_random_traffic(190, 11, 63);
		test_random_traffic(190, 63, 11);
		test_random_traffic(190, 0, 0);
		test_output_backpressure();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ping_pong_byte_ring_buffer_unit_test: PASS");
		else
			$display("ping_pong_byte_ring_buffer_unit_test: FAIL");
		$finish;
	end

endmodule

### sim.f
src/ppbr_pkg.sv
src/ppbr_ring.sv
src/ppbr_ctrl.sv
src/ping_pong_byte_ring_buffer_unit.sv
tb/ping_pong_byte_ring_buffer_unit_test.sv
